[design/prg_pkg.sv]
// Shared types and constants for the pinhole ray generator.
// No dependencies; every other file but prg_if refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package prg_pkg;

  localparam int COORD_BITS       = 12;
  localparam int RSQRT_ITERATIONS = 3;
  localparam int ONE_Q14          = 16384;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 60;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_INV  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_INV = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ASPECT     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FOCAL      = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT      = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_UP         = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BACK       = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_POSITION   = 4'd7;

  typedef logic signed [22:0] cval_t;
  typedef logic signed [15:0] dval_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    cval_t z;
  } cvec_t;

  typedef struct packed {
    dval_t x;
    dval_t y;
    dval_t z;
  } dvec_t;

  typedef struct packed {
    logic [23:0] width_inv;
    logic [23:0] height_inv;
    logic [15:0] aspect_ratio;
    logic [19:0] focal_length;
    logic [47:0] basis_right;
    logic [47:0] basis_up;
    logic [47:0] basis_back;
    logic [59:0] camera_position;
  } cfg_t;

  // pipeline handshake between stages: advance strobe and valid of the item
  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctl_t;

endpackage
`default_nettype wire

[design/prg_if.sv]
// Valid/ready channel interfaces for pixel samples and generated rays.
// Uses no package.
`timescale 1ns / 1ps
`default_nettype none
interface prg_pixel_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [15:0] jitter_u;
  logic [15:0] jitter_v;
  modport source (output valid, pixel_x, pixel_y, jitter_u, jitter_v, input ready);
  modport sink (input valid, pixel_x, pixel_y, jitter_u, jitter_v, output ready);
endinterface

interface prg_ray_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] origin_x;
  logic signed [19:0] origin_y;
  logic signed [19:0] origin_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface
`default_nettype wire

[design/prg_front.sv]
// Screen mapping and camera-space direction, two pipeline stages.
// Depends on prg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prg_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire prg_pkg::stage_ctl_t ctl_i,
  input  wire prg_pkg::cfg_t       cfg_i,
  input  wire logic [11:0]         pixel_x_i,
  input  wire logic [11:0]         pixel_y_i,
  input  wire logic [15:0]         jitter_u_i,
  input  wire logic [15:0]         jitter_v_i,
  output prg_pkg::stage_ctl_t      ctl_o,
  output prg_pkg::cvec_t           c_o
);
  localparam int AW = prg_pkg::COORD_BITS + 16;
  localparam int TW = prg_pkg::COORD_BITS + 14;

  logic [AW+23:0] prod_x, prod_y;
  logic [TW-1:0]  tx_d, ty_d, tx_q, ty_q;
  logic           v1_q, v2_q;
  logic signed [15:0] sx, sy;
  logic [14:0]    sx_mag;
  logic [30:0]    cx_prod;
  logic [18:0]    cx_mag;
  prg_pkg::cvec_t c_d, c_q;

  function automatic logic signed [15:0] to_screen(input logic [TW-1:0] t);
    logic signed [16:0] s;
    s = $signed({1'b0, t[14:0], 1'b0}) - 17'sd16384;
    if (t > TW'(prg_pkg::ONE_Q14)) begin
      return 16'sd16384;
    end
    return s[15:0];
  endfunction

  always_comb begin
    prod_x = {{24{1'b0}}, pixel_x_i[prg_pkg::COORD_BITS-1:0], jitter_u_i} *
             {{AW{1'b0}}, cfg_i.width_inv};
    prod_y = {{24{1'b0}}, pixel_y_i[prg_pkg::COORD_BITS-1:0], jitter_v_i} *
             {{AW{1'b0}}, cfg_i.height_inv};
    tx_d = prod_x[AW+23:26];
    ty_d = prod_y[AW+23:26];
  end

  always_comb begin
    sx      = to_screen(tx_q);
    sy      = to_screen(ty_q);
    sx_mag  = sx[15] ? 15'(-sx) : sx[14:0];
    cx_prod = {16'd0, sx_mag} * {15'd0, cfg_i.aspect_ratio};
    cx_mag  = cx_prod[30:12];
    c_d.x   = sx[15] ? -$signed({4'd0, cx_mag}) : $signed({4'd0, cx_mag});
    c_d.y   = prg_pkg::cval_t'(sy);
    c_d.z   = 23'sd0 - $signed({1'b0, cfg_i.focal_length, 2'b00});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (ctl_i.en) begin
      v1_q <= ctl_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      tx_q <= tx_d;
      ty_q <= ty_d;
      c_q  <= c_d;
    end
  end

  assign ctl_o.en    = ctl_i.en;
  assign ctl_o.valid = v2_q;
  assign c_o         = c_q;
endmodule
`default_nettype wire

[design/prg_norm.sv]
// Length, reciprocal square root by Newton steps, and scaling of the
// camera-space direction to unit length. Depends on prg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prg_norm (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire prg_pkg::stage_ctl_t ctl_i,
  input  wire prg_pkg::cvec_t      c_i,
  output prg_pkg::stage_ctl_t      ctl_o,
  output prg_pkg::dvec_t           d_o
);
  localparam int NS = 3 * prg_pkg::RSQRT_ITERATIONS;

  typedef struct packed {
    prg_pkg::cvec_t c;
    logic           zero;
    logic [5:0]     rs;
    logic [31:0]    m;
    logic [31:0]    y;
    logic [31:0]    y2;
    logic [33:0]    t;
  } it_t;

  // stage A: squares
  logic [21:0] mx, my, mz;
  logic [43:0] sqx_q, sqy_q, sqz_q;
  prg_pkg::cvec_t ca_q, cb_q, cc_q;
  logic        va_q, vb_q, vc_q;
  // stage B: sum
  logic [45:0] len2_q;
  // stage C: leading one
  logic [5:0]  msb_d, msb_q;
  logic [45:0] lenc_q;
  logic        zero_q;
  // stage D: normalize and seed
  logic signed [7:0] sh;
  logic [63:0] mwide;
  it_t         seed;
  it_t         stg_q [NS+1];
  logic        vstg_q [NS+1];
  // final stages
  logic [53:0] px_q, py_q, pz_q;
  logic        sgx_q, sgy_q, sgz_q, zf_q, vp_q, vd_q;
  logic [5:0]  rsf_q;
  prg_pkg::dvec_t d_q;

  function automatic logic [21:0] mag23(input prg_pkg::cval_t v);
    logic [22:0] n;
    n = v[22] ? 23'(-v) : 23'(v);
    return n[21:0];
  endfunction

  function automatic prg_pkg::dval_t scale(input logic [53:0] p, input logic [5:0] rs,
                                           input logic neg);
    logic [53:0] q;
    logic [15:0] u;
    q = p >> rs;
    u = (q > 54'(prg_pkg::ONE_Q14)) ? 16'd16384 : q[15:0];
    return neg ? -$signed(u) : $signed(u);
  endfunction

  always_comb begin
    mx = mag23(c_i.x);
    my = mag23(c_i.y);
    mz = mag23(c_i.z);
  end

  always_comb begin
    msb_d = 6'd0;
    for (int b = 0; b < 46; b++) begin
      if (len2_q[b]) begin
        msb_d = 6'(b);
      end
    end
  end

  always_comb begin
    sh = 8'sd30 - $signed({2'b00, msb_q});
    if (sh[0]) begin
      sh = sh + 8'sd1;
    end
    if (sh[7]) begin
      mwide = {18'd0, lenc_q} >> 8'(-sh);
    end else begin
      mwide = {18'd0, lenc_q} << sh;
    end
    seed      = '0;
    seed.c    = cc_q;
    seed.zero = zero_q;
    seed.rs   = 6'(8'sd31 - (sh >>> 1));
    seed.m    = mwide[31:0];
    seed.y    = mwide[31] ? 32'd671088640 : 32'd939524096;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vstg_q[0] <= 1'b0;
    end else if (ctl_i.en) begin
      va_q <= ctl_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vstg_q[0] <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      sqx_q  <= mx * mx;
      sqy_q  <= my * my;
      sqz_q  <= mz * mz;
      ca_q   <= c_i;
      len2_q <= {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};
      cb_q   <= ca_q;
      msb_q  <= msb_d;
      lenc_q <= len2_q;
      zero_q <= (len2_q == 46'd0);
      cc_q   <= cb_q;
      stg_q[0] <= seed;
    end
  end

  for (genvar k = 0; k < prg_pkg::RSQRT_ITERATIONS; k++) begin : g_iter
    logic [63:0] p0, p1, p2;
    logic [31:0] h;
    it_t s0, s1, s2;

    always_comb begin
      s0    = stg_q[3*k];
      p0    = {32'd0, s0.y} * {32'd0, s0.y};
      s0.y2 = p0[61:30];
      s1    = stg_q[3*k+1];
      p1    = {32'd0, s1.m} * {32'd0, s1.y2};
      s1.t  = {2'b00, p1[61:30]} | {p1[63:62], 32'd0};
      s2    = stg_q[3*k+2];
      h     = (s2.t >= 34'd3221225472) ? 32'd0 : 32'(34'd3221225472 - s2.t);
      p2    = {32'd0, s2.y} * {32'd0, h};
      s2.y  = p2[62:31];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vstg_q[3*k+1] <= 1'b0;
        vstg_q[3*k+2] <= 1'b0;
        vstg_q[3*k+3] <= 1'b0;
      end else if (ctl_i.en) begin
        vstg_q[3*k+1] <= vstg_q[3*k];
        vstg_q[3*k+2] <= vstg_q[3*k+1];
        vstg_q[3*k+3] <= vstg_q[3*k+2];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        stg_q[3*k+1] <= s0;
        stg_q[3*k+2] <= s1;
        stg_q[3*k+3] <= s2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (ctl_i.en) begin
      vp_q <= vstg_q[NS];
      vd_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      px_q  <= {32'd0, mag23(stg_q[NS].c.x)} * {22'd0, stg_q[NS].y};
      py_q  <= {32'd0, mag23(stg_q[NS].c.y)} * {22'd0, stg_q[NS].y};
      pz_q  <= {32'd0, mag23(stg_q[NS].c.z)} * {22'd0, stg_q[NS].y};
      sgx_q <= stg_q[NS].c.x[22];
      sgy_q <= stg_q[NS].c.y[22];
      sgz_q <= stg_q[NS].c.z[22];
      zf_q  <= stg_q[NS].zero;
      rsf_q <= stg_q[NS].rs;
      d_q.x <= zf_q ? 16'sd0 : scale(px_q, rsf_q, sgx_q);
      d_q.y <= zf_q ? 16'sd0 : scale(py_q, rsf_q, sgy_q);
      d_q.z <= zf_q ? 16'sd0 : scale(pz_q, rsf_q, sgz_q);
    end
  end

  assign ctl_o.en    = ctl_i.en;
  assign ctl_o.valid = vd_q;
  assign d_o         = d_q;
endmodule
`default_nettype wire

[design/prg_rotate.sv]
// Rotation of the unit direction into world space, two stages; the second
// stage is the output register. Depends on prg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prg_rotate (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire prg_pkg::stage_ctl_t ctl_i,
  input  wire prg_pkg::cfg_t       cfg_i,
  input  wire prg_pkg::dvec_t      d_i,
  output prg_pkg::stage_ctl_t      ctl_o,
  output prg_pkg::dvec_t           w_o,
  output logic [59:0]              origin_o
);
  logic signed [31:0] pr_q [3], pu_q [3], pb_q [3];
  logic               vg_q, vo_q;
  prg_pkg::dvec_t     w_q;
  logic [59:0]        org_q;
  prg_pkg::dval_t     w_d [3];

  function automatic prg_pkg::dval_t shrink(input logic signed [33:0] a);
    logic [33:0] m;
    logic [19:0] q;
    logic [15:0] u;
    m = a[33] ? 34'(-a) : 34'(a);
    q = m[33:14];
    u = (q > 20'd16384) ? 16'd16384 : q[15:0];
    return a[33] ? -$signed(u) : $signed(u);
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_d[i] = shrink(34'(pr_q[i]) + 34'(pu_q[i]) + 34'(pb_q[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (ctl_i.en) begin
      vg_q <= ctl_i.valid;
      vo_q <= vg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int i = 0; i < 3; i++) begin
        pr_q[i] <= $signed(cfg_i.basis_right[16*i +: 16]) * d_i.x;
        pu_q[i] <= $signed(cfg_i.basis_up[16*i +: 16]) * d_i.y;
        pb_q[i] <= $signed(cfg_i.basis_back[16*i +: 16]) * d_i.z;
      end
      w_q.x <= w_d[0];
      w_q.y <= w_d[1];
      w_q.z <= w_d[2];
      org_q <= cfg_i.camera_position;
    end
  end

  assign ctl_o.en    = ctl_i.en;
  assign ctl_o.valid = vo_q;
  assign w_o         = w_q;
  assign origin_o    = org_q;
endmodule
`default_nettype wire

[design/pinhole_ray_generator.sv]
// Pinhole camera ray generator, top level: configuration registers and the
// front, normalize and rotate pipeline. Depends on prg_pkg, prg_if and the prg_ modules.
//
// Usage:
//   pixel_i carries a pixel position and a sub-pixel jitter; ray_o returns one
//   ray per transfer: the camera position as origin and the unit world
//   direction, both in fixed point.
//   Configuration registers are written through cfg_we_i / cfg_index_i /
//   cfg_data_i, one per cycle; the user must write them only while no ray is
//   in flight, which the block does not enforce. An input transfer reaches
//   ray_o through two stages of screen mapping, four of length and
//   normalization, three per Newton step of the reciprocal square root, two
//   of scaling and two of rotation. One item enters every cycle unless the
//   receiver stalls; the rate is set by the pipeline, which carries a valid bit with each stage.
//   When the receiver stalls, the whole pipeline holds and pixel_i.ready
//   drops; nothing is lost or repeated.
//   Reset clears every valid bit and loads the default camera: unit basis,
//   origin at zero, unit aspect and focal length.
`timescale 1ns / 1ps
`default_nettype none
module pinhole_ray_generator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [prg_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [prg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  prg_pixel_if.sink                          pixel_i,
  prg_ray_if.source                          ray_o
);
  prg_pkg::cfg_t       cfg_q;
  prg_pkg::stage_ctl_t ctl_in, ctl_f, ctl_n, ctl_r;
  prg_pkg::cvec_t      c;
  prg_pkg::dvec_t      d, w;
  logic [59:0]         origin;
  logic                en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_inv       <= 24'd4096;
      cfg_q.height_inv      <= 24'd4096;
      cfg_q.aspect_ratio    <= 16'd4096;
      cfg_q.focal_length    <= 20'd4096;
      cfg_q.basis_right     <= 48'd16384;
      cfg_q.basis_up        <= 48'd16384 << 16;
      cfg_q.basis_back      <= 48'd16384 << 32;
      cfg_q.camera_position <= 60'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        prg_pkg::REG_WIDTH_INV:  cfg_q.width_inv       <= cfg_data_i[23:0];
        prg_pkg::REG_HEIGHT_INV: cfg_q.height_inv      <= cfg_data_i[23:0];
        prg_pkg::REG_ASPECT:     cfg_q.aspect_ratio    <= cfg_data_i[15:0];
        prg_pkg::REG_FOCAL:      cfg_q.focal_length    <= cfg_data_i[19:0];
        prg_pkg::REG_RIGHT:      cfg_q.basis_right     <= cfg_data_i[47:0];
        prg_pkg::REG_UP:         cfg_q.basis_up        <= cfg_data_i[47:0];
        prg_pkg::REG_BACK:       cfg_q.basis_back      <= cfg_data_i[47:0];
        prg_pkg::REG_POSITION:   cfg_q.camera_position <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // advance unless a finished ray waits
  assign en            = !ray_o.valid || ray_o.ready;
  assign pixel_i.ready = en;
  assign ctl_in.en     = en;
  assign ctl_in.valid  = pixel_i.valid;

  prg_front u_front (
    .clk_i, .rst_ni,
    .ctl_i      (ctl_in),
    .cfg_i      (cfg_q),
    .pixel_x_i  (pixel_i.pixel_x),
    .pixel_y_i  (pixel_i.pixel_y),
    .jitter_u_i (pixel_i.jitter_u),
    .jitter_v_i (pixel_i.jitter_v),
    .ctl_o      (ctl_f),
    .c_o        (c)
  );

  prg_norm u_norm (
    .clk_i, .rst_ni,
    .ctl_i (ctl_f),
    .c_i   (c),
    .ctl_o (ctl_n),
    .d_o   (d)
  );

  prg_rotate u_rotate (
    .clk_i, .rst_ni,
    .ctl_i    (ctl_n),
    .cfg_i    (cfg_q),
    .d_i      (d),
    .ctl_o    (ctl_r),
    .w_o      (w),
    .origin_o (origin)
  );

  assign ray_o.valid    = ctl_r.valid;
  assign ray_o.origin_x = origin[19:0];
  assign ray_o.origin_y = origin[39:20];
  assign ray_o.origin_z = origin[59:40];
  assign ray_o.dir_x    = w.x;
  assign ray_o.dir_y    = w.y;
  assign ray_o.dir_z    = w.z;

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ray_o.valid |-> (ray_o.dir_x <= 16'sd16384) && (ray_o.dir_x >= -16'sd16384) &&
                    (ray_o.dir_y <= 16'sd16384) && (ray_o.dir_y >= -16'sd16384) &&
                    (ray_o.dir_z <= 16'sd16384) && (ray_o.dir_z >= -16'sd16384))
    else $error("ray direction out of unit range");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_n.valid |-> (d.x <= 16'sd16384) && (d.x >= -16'sd16384) &&
                    (d.y <= 16'sd16384) && (d.y >= -16'sd16384) &&
                    (d.z <= 16'sd16384) && (d.z >= -16'sd16384))
    else $error("normalized direction out of unit range");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ray_o.valid && !ray_o.ready) |=> ray_o.valid && (!ray_o.ready || pixel_i.ready))
    else $error("stalled ray dropped");
endmodule
`default_nettype wire

[tb/sv/pinhole_ray_generator_tb.sv]
// Testbench for pinhole_ray_generator: drives pixel samples, predicts each ray
// in fixed point and checks every ray transfer. Depends on prg_pkg, prg_if, the RTL.
`timescale 1ns / 1ps
module pinhole_ray_generator_tb;

  typedef struct packed {
    logic signed [19:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
  } ray_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [prg_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [prg_pkg::CFG_DATA_W-1:0]  cfg_data;

  prg_pixel_if pix ();
  prg_ray_if   ray ();

  pinhole_ray_generator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pixel_i     (pix),
    .ray_o       (ray)
  );

  prg_pkg::cfg_t cam;
  ray_t pending_rays[$];
  int   mismatches;
  int   gap_max;
  int   stall_max;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint sat_unit(longint v);
    if (v > prg_pkg::ONE_Q14) return prg_pkg::ONE_Q14;
    if (v < -prg_pkg::ONE_Q14) return -prg_pkg::ONE_Q14;
    return v;
  endfunction

  function automatic longint mul_shift(longint v, longint unsigned mul, int sh);
    longint unsigned r;
    r = (mag(v) * mul) >> sh;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint screen(longint unsigned pixv, longint unsigned jit,
                                    longint unsigned inv);
    longint unsigned p, t;
    longint s;
    p = pixv & ((64'd1 << prg_pkg::COORD_BITS) - 1);
    t = (((p << 16) + jit) * inv) >> 26;
    s = longint'(2 * t) - prg_pkg::ONE_Q14;
    return s > prg_pkg::ONE_Q14 ? prg_pkg::ONE_Q14 : s;
  endfunction

  function automatic ray_t predict_ray(logic [11:0] px, logic [11:0] py,
                                       logic [15:0] ju, logic [15:0] jv);
    longint c[3];
    longint d[3];
    longint acc, w;
    longint unsigned len2, m, y, y2, t, h;
    int msb, sh, k, rs;
    ray_t r;
    d = '{0, 0, 0};
    c[0] = mul_shift(screen(px, ju, cam.width_inv), cam.aspect_ratio, 12);
    c[1] = screen(py, jv, cam.height_inv);
    c[2] = -longint'({44'd0, cam.focal_length} << 2);
    len2 = 0;
    for (int i = 0; i < 3; i++) len2 += mag(c[i]) * mag(c[i]);
    if (len2 != 0) begin
      msb = 63;
      while (len2[msb] == 1'b0) msb--;
      sh = 30 - msb;
      if (sh % 2 != 0) sh += 1;
      m = sh >= 0 ? (len2 << sh) : (len2 >> (-sh));
      y = m < (64'd1 << 31) ? 64'd939524096 : 64'd671088640;
      for (int it = 0; it < prg_pkg::RSQRT_ITERATIONS; it++) begin
        y2 = (y * y) >> 30;
        t = (m * y2) >> 30;
        h = t >= (64'd3 << 30) ? 64'd0 : (64'd3 << 30) - t;
        y = (y * h) >> 31;
      end
      k = (sh - 2) / 2;
      rs = 30 - k;
      for (int i = 0; i < 3; i++) d[i] = sat_unit(mul_shift(c[i], y, rs));
    end
    for (int i = 0; i < 3; i++) begin
      acc = longint'($signed(cam.basis_right[16*i +: 16])) * d[0]
          + longint'($signed(cam.basis_up[16*i +: 16])) * d[1]
          + longint'($signed(cam.basis_back[16*i +: 16])) * d[2];
      w = sat_unit(mul_shift(acc, 1, 14));
      case (i)
        0: begin r.ox = cam.camera_position[19:0];  r.dx = w[15:0]; end
        1: begin r.oy = cam.camera_position[39:20]; r.dy = w[15:0]; end
        default: begin r.oz = cam.camera_position[59:40]; r.dz = w[15:0]; end
      endcase
    end
    return r;
  endfunction

  task automatic wait_idle();
    while (pending_rays.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [prg_pkg::CFG_INDEX_W-1:0] idx,
                           logic [prg_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      prg_pkg::REG_WIDTH_INV:  cam.width_inv       = val[23:0];
      prg_pkg::REG_HEIGHT_INV: cam.height_inv      = val[23:0];
      prg_pkg::REG_ASPECT:     cam.aspect_ratio    = val[15:0];
      prg_pkg::REG_FOCAL:      cam.focal_length    = val[19:0];
      prg_pkg::REG_RIGHT:      cam.basis_right     = val[47:0];
      prg_pkg::REG_UP:         cam.basis_up        = val[47:0];
      prg_pkg::REG_BACK:       cam.basis_back      = val[47:0];
      prg_pkg::REG_POSITION:   cam.camera_position = val[59:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [11:0] px, logic [11:0] py,
                            logic [15:0] ju, logic [15:0] jv);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid    <= 1'b1;
    pix.pixel_x  <= px;
    pix.pixel_y  <= py;
    pix.jitter_u <= ju;
    pix.jitter_v <= jv;
    pending_rays = {pending_rays, predict_ray(px, py, ju, jv)};
    do @(posedge clk_i); while (!pix.ready);
  endtask

  task automatic end_burst();
    pix.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_camera(bit unit_basis);
    int w, hgt;
    w   = $urandom_range(4096, 1);
    hgt = $urandom_range(4096, 1);
    write_reg(prg_pkg::REG_WIDTH_INV, (60'd1 << 24) / w);
    write_reg(prg_pkg::REG_HEIGHT_INV, (60'd1 << 24) / hgt);
    write_reg(prg_pkg::REG_ASPECT, 60'($urandom_range(16384, 1024)));
    write_reg(prg_pkg::REG_FOCAL, 60'($urandom_range(40000, 1)));
    if (unit_basis) begin
      write_reg(prg_pkg::REG_RIGHT, 60'(16'(-16384)));
      write_reg(prg_pkg::REG_UP, 60'(16384) << 32);
      write_reg(prg_pkg::REG_BACK, 60'(16384) << 16);
    end else begin
      write_reg(prg_pkg::REG_RIGHT, 60'({$urandom, $urandom}));
      write_reg(prg_pkg::REG_UP, 60'({$urandom, $urandom}));
      write_reg(prg_pkg::REG_BACK, 60'({$urandom, $urandom}));
    end
    write_reg(prg_pkg::REG_POSITION, 60'({$urandom, $urandom}));
  endtask

  task automatic test_default_camera();
    send_pixel(12'd0, 12'd0, 16'd0, 16'd0);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(12'd2048, 12'd0, 16'h8000, 16'hFFFF);
    send_pixel(12'd0, 12'd4095, 16'h0001, 16'd0);
    send_pixel(12'hAAA, 12'h555, 16'hAAAA, 16'h5555);
    end_burst();
  endtask

  task automatic test_zero_length();
    wait_idle();
    write_reg(prg_pkg::REG_ASPECT, 60'd0);
    write_reg(prg_pkg::REG_FOCAL, 60'd0);
    write_reg(prg_pkg::REG_POSITION, {20'h80000, 20'h7FFFF, 20'h12345});
    send_pixel(12'd2048, 12'd2048, 16'd0, 16'd0);
    send_pixel(12'd2048, 12'd0, 16'd0, 16'd0);
    send_pixel(12'd0, 12'd2048, 16'hFFFF, 16'd0);
    end_burst();
  endtask

  task automatic test_inverse_extremes();
    wait_idle();
    write_reg(prg_pkg::REG_ASPECT, 60'hFFFF);
    write_reg(prg_pkg::REG_FOCAL, 60'hFFFFF);
    write_reg(prg_pkg::REG_WIDTH_INV, 60'd0);
    write_reg(prg_pkg::REG_HEIGHT_INV, {36'hFFFFFFFFF, 24'hFFFFFF});
    write_reg(4'd8, 60'd123);
    write_reg(4'd15, {60{1'b1}});
    send_pixel(12'd100, 12'd100, 16'd7, 16'd7);
    send_pixel(12'hFFF, 12'd0, 16'hFFFF, 16'd0);
    send_pixel(12'd0, 12'd0, 16'd0, 16'd0);
    end_burst();
    wait_idle();
    write_reg(prg_pkg::REG_WIDTH_INV, 60'hFFFFFF);
    write_reg(prg_pkg::REG_HEIGHT_INV, 60'd0);
    write_reg(prg_pkg::REG_FOCAL, 60'd1);
    write_reg(prg_pkg::REG_RIGHT, {60{1'b1}});
    write_reg(prg_pkg::REG_UP, 60'h000_8000_8000_8000);
    write_reg(prg_pkg::REG_BACK, 60'h000_7FFF_7FFF_7FFF);
    send_pixel(12'd0, 12'd0, 16'd0, 16'd0);
    send_pixel(12'd1, 12'hFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(12'hFFF, 12'd3, 16'd1, 16'h8000);
    end_burst();
  endtask

  task automatic test_random_rays();
    int w, hgt;
    for (int phase = 0; phase < 10; phase++) begin
      wait_idle();
      random_camera(phase % 2 == 0);
      gap_max   = (phase % 3 == 1) ? 0 : 16;
      stall_max = (phase % 4 == 2) ? 0 : 16;
      w   = (64'd1 << 24) / (cam.width_inv == 0 ? 1 : cam.width_inv);
      hgt = (64'd1 << 24) / (cam.height_inv == 0 ? 1 : cam.height_inv);
      for (int n = 0; n < 50; n++) begin
        if (n == 25 && phase == 5) begin
          end_burst();
          wait_idle();
        end
        if ($urandom_range(9, 0) < 8)
          send_pixel(12'($urandom_range(w - 1, 0)), 12'($urandom_range(hgt - 1, 0)),
                     16'($urandom), 16'($urandom));
        else
          send_pixel(12'($urandom), 12'($urandom), 16'($urandom), 16'($urandom));
      end
      end_burst();
    end
    gap_max   = 16;
    stall_max = 16;
  endtask

  // sink side: random stall before each transfer
  initial begin
    int n;
    ray.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(stall_max, 0);
      if (n > 0) begin
        ray.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      ray.ready <= 1'b1;
      do @(posedge clk_i); while (!ray.valid);
    end
  end

  always @(posedge clk_i) begin
    ray_t got, want;
    if (rst_ni && ray.valid && ray.ready) begin
      got = '{ray.origin_x, ray.origin_y, ray.origin_z, ray.dir_x, ray.dir_y, ray.dir_z};
      if (pending_rays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected ray %p", got);
      end else begin
        want = pending_rays.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("ray mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    mismatches   = 0;
    gap_max      = 16;
    stall_max    = 16;
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    pix.valid    <= 1'b0;
    pix.pixel_x  <= '0;
    pix.pixel_y  <= '0;
    pix.jitter_u <= '0;
    pix.jitter_v <= '0;
    cam = '{24'd4096, 24'd4096, 16'd4096, 20'd4096, 48'd16384,
            48'd16384 << 16, 48'd16384 << 32, 60'd0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_camera();
    test_zero_length();
    test_inverse_extremes();
    test_random_rays();
    wait_idle();
    if (mismatches == 0 && pending_rays.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

[files.f]
design/prg_pkg.sv
design/prg_if.sv
design/prg_front.sv
design/prg_norm.sv
design/prg_rotate.sv
design/pinhole_ray_generator.sv
tb/sv/pinhole_ray_generator_tb.sv
